[design/lzsr_pkg.sv]
// ----------------------------------------------------------------------------
// lzsr_pkg: shared types and constants of the LZ / slide / RLE decompressor
// Word layouts, controller-datapath command and status, register indexes.
// ----------------------------------------------------------------------------
package lzsr_pkg;

	localparam int OUT_LANES = 8;
	localparam int SIZE_BITS = 24;
	localparam int LANE_W    = 8 * OUT_LANES;
	localparam int ADDR_W    = 3;

	localparam logic [23:0] SIZE_MASK = (SIZE_BITS >= 24) ? 24'hFFFFFF :
		24'((64'd1 << SIZE_BITS) - 64'd1);

	localparam logic [9:0]  RING_START = 10'd958;
	localparam int          HIST_DEPTH = 4096;
	localparam logic [10:0] RING_SIZE  = 11'd1024;

	// Register indexes of the configuration port.
	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_SIZE   = 1'b1;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNC     = 3'd1;
	localparam logic [2:0] ST_OVERRUN   = 3'd2;
	localparam logic [2:0] ST_BAD_DIST  = 3'd3;
	localparam logic [2:0] ST_BAD_RUN   = 3'd4;

	// Action decided by the parser for one compressed byte.
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_EMIT = 2'd1;
	localparam logic [1:0] ACT_COPY = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_word_t;

	typedef struct packed {
		logic [LANE_W-1:0] out_bytes;
		logic [3:0]        byte_count;
		logic              last_of_run;
		logic              stream_done;
		logic [2:0]        status;
		logic [24:0]       bytes_consumed;
	} out_word_t;

	typedef struct packed {
		logic capture;
		logic start;
		logic parse;
		logic emit;
		logic emit_mem;
		logic rd;
		logic fin;
		logic push_mid;
		logic push_last;
	} cmd_t;

	typedef struct packed {
		logic       phase_idle;
		logic [1:0] act;
		logic       last_cnt;
		logic       can_emit;
		logic       out_free;
		logic       flush_need;
		logic       lane_full;
		logic       done;
	} stat_t;

endpackage

[design/lzsr_ram.sv]
// ----------------------------------------------------------------------------
// lzsr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/lzsr_datapath.sv]
// ----------------------------------------------------------------------------
// lzsr_datapath: parser state, history memory and output packing
// Executes the commands of the controller and reports status back.
// ----------------------------------------------------------------------------
module lzsr_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [31:0]         cfg_data,
	output logic [2:0]          fmt_reg,
	output logic [23:0]         size_reg,
	input  lzsr_pkg::in_word_t  in_word,
	input  lzsr_pkg::cmd_t      cmd,
	output lzsr_pkg::stat_t     stat,
	output logic                out_valid,
	input  logic                out_stall,
	output lzsr_pkg::out_word_t out_word
);

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_START    = 4'd1;
	localparam logic [3:0] PH_TOK      = 4'd2;
	localparam logic [3:0] PH_SECOND   = 4'd3;
	localparam logic [3:0] PH_THIRD    = 4'd4;
	localparam logic [3:0] PH_HEADER   = 4'd5;
	localparam logic [3:0] PH_FLAGWORD = 4'd6;
	localparam logic [3:0] PH_RLE_LIT  = 4'd7;
	localparam logic [3:0] PH_RLE_FILL = 4'd8;

	logic [2:0]  fmt_q;
	logic [23:0] size_q;
	logic [7:0]  b_q;
	logic        eoi_q;
	logic [23:0] dec_q;
	logic [24:0] cons_q;
	logic [9:0]  ring_q;
	logic [10:0] fill_q;
	logic [15:0] flag_q;
	logic [31:0] fw_q;
	logic [5:0]  bits_q;
	logic [3:0]  phase_q;
	logic [7:0]  hf_q;
	logic [7:0]  hs2_q;
	logic [6:0]  rem_q;
	logic [2:0]  hs_q;
	logic [2:0]  err_q;
	logic [8:0]  cnt_q;
	logic [9:0]  src_q;
	logic [12:0] dist_q;
	logic        zero_q;
	logic [63:0] lane_q;
	logic [3:0]  lane_n_q;
	logic        done_q;
	logic        ovalid_q;
	lzsr_pkg::out_word_t oword_q;

	logic [2:0]  fmt_eff;
	logic        is_lzss;
	logic        is_slide;
	logic [23:0] size_eff;
	logic [23:0] room;
	logic        early;
	logic        start_full;
	logic        out_free;

	// Parser next values.
	logic [15:0] n_flag;
	logic [31:0] n_fw;
	logic [5:0]  n_bits;
	logic [3:0]  n_phase;
	logic [7:0]  n_hf;
	logic [7:0]  n_hs2;
	logic [6:0]  n_rem;
	logic [2:0]  n_hs;
	logic [2:0]  n_err;
	logic [1:0]  n_act;
	logic [8:0]  n_cnt;
	logic [9:0]  n_src;
	logic [12:0] n_dist;
	logic [15:0] sh;
	logic        tok;
	logic [8:0]  lcnt;
	logic        do_copy;
	logic [8:0]  ccnt;
	logic [12:0] cdist;
	logic [2:0]  hs1;
	logic [6:0]  rem1;

	logic [7:0]  ram_rdata;
	logic [7:0]  emit_val;
	logic        emit_any;
	logic        hist_we;
	logic [11:0] hist_waddr;
	logic [11:0] hist_raddr;
	logic [9:0]  ring_off;

	assign fmt_eff    = (fmt_q > 3'd5) ? 3'd0 : fmt_q;
	assign is_lzss    = (fmt_eff == 3'd1);
	assign is_slide   = (fmt_eff >= 3'd2) && (fmt_eff <= 3'd4);
	assign size_eff   = size_q & lzsr_pkg::SIZE_MASK;
	assign room       = size_eff - dec_q;
	assign start_full = (phase_q == PH_START) && (dec_q >= size_eff);
	assign early      = start_full;
	assign out_free   = !ovalid_q || !out_stall;
	assign fmt_reg    = fmt_q;
	assign size_reg   = size_q;

	always_comb begin
		n_flag  = flag_q;
		n_fw    = fw_q;
		n_bits  = bits_q;
		n_phase = phase_q;
		n_hf    = hf_q;
		n_hs2   = hs2_q;
		n_rem   = rem_q;
		n_hs    = hs_q;
		n_err   = err_q;
		n_act   = lzsr_pkg::ACT_NONE;
		n_cnt   = 9'd1;
		n_src   = src_q;
		n_dist  = dist_q;
		sh      = flag_q;
		tok     = 1'b1;
		lcnt    = {3'b000, b_q[5:0]} + 9'd3;
		do_copy = 1'b0;
		ccnt    = 9'd0;
		cdist   = 13'd0;
		hs1     = hs_q + 3'd1;
		rem1    = (rem_q != 7'd0) ? rem_q - 7'd1 : 7'd0;
		if (!early) begin
			case (fmt_eff)
				3'd1: begin
					if (phase_q == PH_START) begin
						sh = {1'b0, flag_q[15:1]};
						n_phase = PH_TOK;
						if (!sh[8]) begin
							n_flag = {8'hFF, b_q};
							tok = 1'b0;
						end else begin
							n_flag = sh;
						end
					end
					if (phase_q == PH_START || phase_q == PH_TOK) begin
						if (tok) begin
							if (sh[0]) begin
								n_act = lzsr_pkg::ACT_EMIT;
								n_phase = PH_START;
							end else begin
								n_hf = b_q;
								n_phase = PH_SECOND;
							end
						end
					end else if ({15'd0, lcnt} > room) begin
						n_err = lzsr_pkg::ST_OVERRUN;
					end else begin
						n_act = lzsr_pkg::ACT_COPY;
						n_cnt = lcnt;
						n_src = {b_q[7:6], hf_q};
						n_phase = PH_START;
					end
				end
				3'd2, 3'd3, 3'd4: begin
					case (phase_q)
						PH_HEADER: begin
							if (hs1 >= 3'd4) begin
								n_hs = 3'd0;
								n_phase = PH_START;
							end else begin
								n_hs = hs1;
							end
						end
						PH_FLAGWORD: begin
							n_fw = {fw_q[23:0], b_q};
							if (hs1 >= 3'd4) begin
								n_hs = 3'd0;
								n_bits = 6'd32;
								n_phase = PH_START;
							end else begin
								n_hs = hs1;
							end
						end
						PH_SECOND: begin
							n_hs2 = b_q;
							if (hf_q[7:4] != 4'd0) begin
								do_copy = 1'b1;
								ccnt = {5'd0, hf_q[7:4]} + 9'd2;
							end else begin
								n_phase = PH_THIRD;
							end
						end
						PH_THIRD: begin
							do_copy = 1'b1;
							ccnt = {1'b0, b_q} + 9'd18;
						end
						default: begin
							if (bits_q == 6'd0) begin
								n_fw = {24'd0, b_q};
								n_hs = 3'd1;
								n_phase = PH_FLAGWORD;
							end else if (fw_q[31]) begin
								n_act = lzsr_pkg::ACT_EMIT;
								n_fw = {fw_q[30:0], 1'b0};
								n_bits = bits_q - 6'd1;
								n_phase = PH_START;
							end else begin
								n_hf = b_q;
								n_phase = PH_SECOND;
							end
						end
					endcase
					if (do_copy) begin
						cdist = {1'b0, hf_q[3:0], n_hs2} + 13'd1;
						if ({15'd0, ccnt} > room) begin
							n_err = lzsr_pkg::ST_OVERRUN;
						end else if (fmt_eff != 3'd2 && {11'd0, cdist} > dec_q) begin
							n_err = lzsr_pkg::ST_BAD_DIST;
						end else begin
							n_act = lzsr_pkg::ACT_COPY;
							n_cnt = ccnt;
							n_dist = cdist;
							n_fw = {fw_q[30:0], 1'b0};
							n_bits = (bits_q != 6'd0) ? bits_q - 6'd1 : 6'd0;
							n_phase = PH_START;
						end
					end
				end
				3'd5: begin
					case (phase_q)
						PH_RLE_LIT: begin
							n_act = lzsr_pkg::ACT_EMIT;
							n_rem = rem1;
							if (rem1 == 7'd0) begin
								n_phase = PH_START;
							end
						end
						PH_RLE_FILL: begin
							n_act = lzsr_pkg::ACT_EMIT;
							n_cnt = {2'b00, rem_q};
							n_rem = 7'd0;
							n_phase = PH_START;
						end
						default: begin
							if (b_q[6:0] == 7'd0 || {17'd0, b_q[6:0]} > room) begin
								n_err = lzsr_pkg::ST_BAD_RUN;
							end else begin
								n_rem = b_q[6:0];
								n_phase = b_q[7] ? PH_RLE_LIT : PH_RLE_FILL;
							end
						end
					endcase
				end
				default: begin
					n_act = lzsr_pkg::ACT_EMIT;
				end
			endcase
		end
	end

	// History: LZSS ring in the low 1024 entries, slide window over all 4096.
	assign emit_any   = cmd.emit || cmd.emit_mem;
	assign emit_val   = cmd.emit_mem ? (zero_q ? 8'd0 : ram_rdata) : b_q;
	assign hist_we    = emit_any && (is_lzss || is_slide);
	assign hist_waddr = is_lzss ? {2'b00, ring_q} : dec_q[11:0];
	assign hist_raddr = is_lzss ? {2'b00, src_q} : dec_q[11:0] - dist_q[11:0];
	assign ring_off   = src_q - lzsr_pkg::RING_START;

	lzsr_ram #(
		.WIDTH(8),
		.DEPTH(lzsr_pkg::HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (emit_val),
		.re    (cmd.rd),
		.raddr (hist_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= 3'd0;
			size_q   <= 24'd0;
			phase_q  <= PH_IDLE;
			err_q    <= lzsr_pkg::ST_OK;
			lane_n_q <= 4'd0;
			ovalid_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == lzsr_pkg::REG_FORMAT) begin
					fmt_q <= cfg_data[2:0];
				end else begin
					size_q <= cfg_data[23:0];
				end
				phase_q <= PH_IDLE;
			end
			if (cmd.start) begin
				err_q   <= lzsr_pkg::ST_OK;
				phase_q <= is_slide ? PH_HEADER : PH_START;
			end
			if (cmd.parse) begin
				err_q   <= n_err;
				phase_q <= n_phase;
			end
			if (cmd.fin) begin
				done_q <= (err_q != lzsr_pkg::ST_OK) || start_full || eoi_q;
				if (err_q == lzsr_pkg::ST_OK && !start_full && eoi_q) begin
					err_q <= lzsr_pkg::ST_TRUNC;
				end
			end
			if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			if (emit_any) begin
				if (lane_n_q == 4'(lzsr_pkg::OUT_LANES)) begin
					ovalid_q <= 1'b1;
					lane_n_q <= 4'd1;
				end else begin
					lane_n_q <= lane_n_q + 4'd1;
				end
			end
			if (cmd.push_mid || cmd.push_last) begin
				ovalid_q <= 1'b1;
				lane_n_q <= 4'd0;
			end
			if (cmd.push_last && done_q) begin
				phase_q <= PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			b_q   <= in_word.data_byte;
			eoi_q <= in_word.end_of_input;
		end
		if (cmd.start) begin
			dec_q  <= 24'd0;
			cons_q <= 25'd0;
			ring_q <= lzsr_pkg::RING_START;
			fill_q <= 11'd0;
			flag_q <= 16'd0;
			fw_q   <= 32'd0;
			bits_q <= 6'd0;
			hf_q   <= 8'd0;
			hs2_q  <= 8'd0;
			rem_q  <= 7'd0;
			hs_q   <= 3'd0;
			lane_q <= 64'd0;
		end
		if (cmd.parse) begin
			if (!early) begin
				cons_q <= cons_q + 25'd1;
			end
			flag_q <= n_flag;
			fw_q   <= n_fw;
			bits_q <= n_bits;
			hf_q   <= n_hf;
			hs2_q  <= n_hs2;
			rem_q  <= n_rem;
			hs_q   <= n_hs;
			cnt_q  <= n_cnt;
			src_q  <= n_src;
			dist_q <= n_dist;
		end
		if (cmd.rd) begin
			if (is_lzss) begin
				zero_q <= ({1'b0, ring_off} >= fill_q);
				src_q  <= src_q + 10'd1;
			end else begin
				zero_q <= ({11'd0, dist_q} > dec_q);
			end
		end
		if (emit_any) begin
			dec_q <= dec_q + 24'd1;
			cnt_q <= cnt_q - 9'd1;
			if (is_lzss) begin
				ring_q <= ring_q + 10'd1;
				if (fill_q != lzsr_pkg::RING_SIZE) begin
					fill_q <= fill_q + 11'd1;
				end
			end
			if (lane_n_q == 4'(lzsr_pkg::OUT_LANES)) begin
				oword_q <= '{out_bytes: lane_q, byte_count: lane_n_q, last_of_run: 1'b0,
					stream_done: 1'b0, status: lzsr_pkg::ST_OK, bytes_consumed: 25'd0};
				lane_q <= {56'd0, emit_val};
			end else begin
				lane_q <= lane_q | ({56'd0, emit_val} << {lane_n_q[2:0], 3'b000});
			end
		end
		if (cmd.push_mid) begin
			oword_q <= '{out_bytes: lane_q, byte_count: lane_n_q, last_of_run: 1'b0,
				stream_done: 1'b0, status: lzsr_pkg::ST_OK, bytes_consumed: 25'd0};
			lane_q <= 64'd0;
		end
		if (cmd.push_last) begin
			oword_q <= '{out_bytes: lane_q, byte_count: lane_n_q, last_of_run: 1'b1,
				stream_done: done_q,
				status: done_q ? err_q : lzsr_pkg::ST_OK,
				bytes_consumed: done_q ? cons_q : 25'd0};
			lane_q <= 64'd0;
		end
	end

	assign out_valid = ovalid_q;
	assign out_word  = oword_q;

	assign stat.phase_idle = (phase_q == PH_IDLE);
	assign stat.act        = n_act;
	assign stat.last_cnt   = (cnt_q == 9'd1);
	assign stat.can_emit   = (lane_n_q != 4'(lzsr_pkg::OUT_LANES)) || out_free;
	assign stat.out_free   = out_free;
	assign stat.flush_need = (lane_n_q != 4'd0) || done_q;
	assign stat.lane_full  = (lane_n_q == 4'(lzsr_pkg::OUT_LANES));
	assign stat.done       = done_q;

endmodule

[design/lzsr_ctrl.sv]
// ----------------------------------------------------------------------------
// lzsr_ctrl: sequencing state machine of the decompressor
// Steps each compressed byte through start (for a new stream), parse, emission and flush.
// ----------------------------------------------------------------------------
module lzsr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lzsr_pkg::stat_t stat,
	output lzsr_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_PARSE = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;
	localparam logic [2:0] S_CRD   = 3'd4;
	localparam logic [2:0] S_CWR   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;
	localparam logic [2:0] S_FLUSH = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = stat.phase_idle ? S_START : S_PARSE;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d = S_PARSE;
			end
			S_PARSE: begin
				cmd.parse = 1'b1;
				case (stat.act)
					lzsr_pkg::ACT_EMIT: state_d = S_EMIT;
					lzsr_pkg::ACT_COPY: state_d = S_CRD;
					default:            state_d = S_FIN;
				endcase
			end
			S_EMIT: begin
				if (stat.can_emit) begin
					cmd.emit = 1'b1;
					if (stat.last_cnt) begin
						state_d = S_FIN;
					end
				end
			end
			S_CRD: begin
				cmd.rd = 1'b1;
				state_d = S_CWR;
			end
			S_CWR: begin
				if (stat.can_emit) begin
					cmd.emit_mem = 1'b1;
					state_d = stat.last_cnt ? S_FIN : S_CRD;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (!stat.flush_need) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					if (stat.done && stat.lane_full) begin
						cmd.push_mid = 1'b1;
					end else begin
						cmd.push_last = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/lz_slide_rle_decompressor.sv]
// ----------------------------------------------------------------------------
// lz_slide_rle_decompressor: five-format streaming decompressor
// Raw, LZSS, slide LZ (lenient and strict) and run-length decoding, with
// decoded bytes packed up to eight per output word.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Word
//  comp      in         comp_valid/stall    in_word_t: data_byte, end_of_input
//  dec       out        dec_valid/stall     out_word_t: bytes, count, flags
//  apb       in/out     psel/penable/pready format and decoded size registers
//
// Each compressed byte passes through capture, parse, wrap-up and flush (and a
// start step when it opens a stream); literal and run bytes are emitted one per
// cycle unless emission waits, back-reference bytes by a history read, then write.
// Reset clears all control state; the history needs no clearing pass, since
// the LZSS ring tracks a fill count and slide copies read only written bytes.
// A stalled output holds its word; emission waits only when the packing lane
// is full and the output register still holds an untaken word.
//
module lz_slide_rle_decompressor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               comp_valid,
	output logic                               comp_stall,
	input  lzsr_pkg::in_word_t                 comp_word,
	output logic                               dec_valid,
	input  logic                               dec_stall,
	output lzsr_pkg::out_word_t                dec_word,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lzsr_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	lzsr_pkg::cmd_t  cmd;
	lzsr_pkg::stat_t stat;
	logic            cfg_we;
	logic [2:0]      fmt_reg;
	logic [23:0]     size_reg;

	// Registers are written on the access phase; the port never waits.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == lzsr_pkg::REG_FORMAT) ? {29'd0, fmt_reg} :
		{8'd0, size_reg};

	// The controller sequences one compressed byte at a time.
	lzsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (comp_valid),
		.in_stall (comp_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the parser state, history and output register.
	lzsr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (paddr[2]),
		.cfg_data  (pwdata),
		.fmt_reg   (fmt_reg),
		.size_reg  (size_reg),
		.in_word   (comp_word),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (dec_valid),
		.out_stall (dec_stall),
		.out_word  (dec_word)
	);

	// Words that do not end a stream carry no status and no byte total.
	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_word.stream_done |->
			dec_word.status == lzsr_pkg::ST_OK && dec_word.bytes_consumed == 25'd0)
		else $error("status reported on a word that does not end the stream");

	// A packed word never claims more bytes than the lanes hold.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid |-> dec_word.byte_count <= 4'(lzsr_pkg::OUT_LANES))
		else $error("byte count exceeds lane count");

	// One compressed byte is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		comp_valid && !comp_stall |=> comp_stall)
		else $error("second byte taken before the first was finished");

	// A word that ends the stream is always the last one of its byte.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_word.stream_done |-> dec_word.last_of_run)
		else $error("stream end flagged on a word that is not last");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for lz_slide_rle_decompressor
// Writes the format and size registers over APB, feeds compressed streams of
// every format (directed corner cases, then random well-formed streams mixed
// with noise), and checks each decoded word against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Format codes of the format register.
	localparam int FMT_RAW     = 0;
	localparam int FMT_LZSS    = 1;
	localparam int FMT_SLIDE   = 2;
	localparam int FMT_STRICT3 = 3;
	localparam int FMT_STRICT4 = 4;
	localparam int FMT_RLE     = 5;
	localparam int FMT_SPARE7  = 7;

	localparam logic [lzsr_pkg::ADDR_W-1:0] ADDR_FORMAT =
		lzsr_pkg::ADDR_W'({lzsr_pkg::REG_FORMAT, 2'b00});
	localparam logic [lzsr_pkg::ADDR_W-1:0] ADDR_SIZE   =
		lzsr_pkg::ADDR_W'({lzsr_pkg::REG_SIZE, 2'b00});
	localparam int SETTLE_CYCLES = 60;

	// ------------------------------------------------------------------
	// Scoreboard: tracks the decoder state, predicts the decoded words
	// caused by each accepted compressed byte and checks what comes out.
	// ------------------------------------------------------------------
	class decomp_scoreboard;
		typedef enum logic [3:0] {
			PH_IDLE, PH_START, PH_TOK, PH_SECOND, PH_THIRD,
			PH_HEADER, PH_FLAGWORD, PH_RLE_LIT, PH_RLE_FILL
		} parse_phase_e;

		bit [2:0]     fmt_reg;
		bit [23:0]    size_reg;
		byte unsigned hist[lzsr_pkg::HIST_DEPTH];
		int unsigned  dec_cnt, cons_cnt, ring_ptr, lzss_shift, flag_word, bits_left;
		int unsigned  held1, held2, rle_left, hdr_cnt;
		logic [2:0]   err;
		parse_phase_e phase;
		logic [63:0]  lane;
		int unsigned  lane_n;
		int           step_n;
		lzsr_pkg::out_word_t pending_words[$];
		int           errors;
		int           words_seen;

		function new();
			fmt_reg = 0;
			size_reg = 0;
			errors = 0;
			words_seen = 0;
			start_stream();
			phase = PH_IDLE;
		endfunction

		function int unsigned fmt_eff();
			return (fmt_reg > FMT_RLE) ? FMT_RAW : fmt_reg;
		endfunction

		function void configure(int idx, int unsigned val);
			if (idx == lzsr_pkg::REG_FORMAT) fmt_reg = val[2:0];
			else size_reg = val[23:0];
			phase = PH_IDLE;
		endfunction

		function void start_stream();
			int unsigned f;
			f = fmt_eff();
			foreach (hist[i]) hist[i] = 0;
			dec_cnt = 0; cons_cnt = 0; ring_ptr = lzsr_pkg::RING_START;
			lzss_shift = 0; flag_word = 0; bits_left = 0;
			held1 = 0; held2 = 0; rle_left = 0; hdr_cnt = 0;
			err = lzsr_pkg::ST_OK;
			phase = (f >= FMT_SLIDE && f <= FMT_STRICT4) ? PH_HEADER : PH_START;
		endfunction

		function void put_word(bit last, bit done);
			lzsr_pkg::out_word_t r;
			r.out_bytes = lane;
			r.byte_count = lane_n[3:0];
			r.last_of_run = last;
			r.stream_done = done;
			r.status = done ? err : lzsr_pkg::ST_OK;
			r.bytes_consumed = done ? cons_cnt[24:0] : 25'd0;
			pending_words.push_back(r);
			step_n++;
			lane = 0;
			lane_n = 0;
		endfunction

		function void emit(int unsigned v);
			lane |= 64'(v & 255) << (8 * lane_n);
			lane_n++;
			dec_cnt++;
			if (lane_n >= lzsr_pkg::OUT_LANES) put_word(0, 0);
		endfunction

		function void ring_put(int unsigned v);
			hist[ring_ptr & 1023] = v[7:0];
			ring_ptr = (ring_ptr + 1) & 1023;
			emit(v);
		endfunction

		function void lzss_byte(int unsigned b, int unsigned size);
			int unsigned pos, cnt;
			if (phase == PH_START) begin
				lzss_shift = (lzss_shift >> 1) & 32'hffff;
				phase = PH_TOK;
				if ((lzss_shift & 256) == 0) begin
					lzss_shift = b | 32'hff00;
					return;
				end
			end
			if (phase == PH_TOK) begin
				if (lzss_shift & 1) begin
					ring_put(b);
					phase = PH_START;
				end else begin
					held1 = b;
					phase = PH_SECOND;
				end
				return;
			end
			pos = held1 | ((b & 192) << 2);
			cnt = (b & 63) + 3;
			if (cnt > size - dec_cnt) begin
				err = lzsr_pkg::ST_OVERRUN;
				return;
			end
			for (int unsigned k = 0; k < cnt; k++) ring_put(hist[(pos + k) & 1023]);
			phase = PH_START;
		endfunction

		function void window_put(int unsigned v);
			hist[dec_cnt & 4095] = v[7:0];
			emit(v);
		endfunction

		function void token_done();
			flag_word = flag_word << 1;
			bits_left = (bits_left != 0) ? bits_left - 1 : 0;
			phase = PH_START;
		endfunction

		function void window_copy(int unsigned cnt, int unsigned size, int unsigned f);
			int unsigned back_dist, v;
			back_dist = (((held1 & 15) << 8) | held2) + 1;
			if (cnt > size - dec_cnt) begin
				err = lzsr_pkg::ST_OVERRUN;
				return;
			end
			if (f != FMT_SLIDE && back_dist > dec_cnt) begin
				err = lzsr_pkg::ST_BAD_DIST;
				return;
			end
			for (int unsigned k = 0; k < cnt; k++) begin
				// The lenient format reads zeros before the stream start.
				v = (back_dist > dec_cnt) ? 0 : hist[(dec_cnt - back_dist) & 4095];
				window_put(v);
			end
			token_done();
		endfunction

		function void slide_byte(int unsigned b, int unsigned size, int unsigned f);
			case (phase)
				PH_HEADER: begin
					hdr_cnt++;
					if (hdr_cnt >= 4) begin
						hdr_cnt = 0;
						phase = PH_START;
					end
				end
				PH_FLAGWORD: begin
					flag_word = (flag_word << 8) | b;
					hdr_cnt++;
					if (hdr_cnt >= 4) begin
						hdr_cnt = 0;
						bits_left = 32;
						phase = PH_START;
					end
				end
				PH_SECOND: begin
					held2 = b;
					if (held1 >> 4) window_copy((held1 >> 4) + 2, size, f);
					else phase = PH_THIRD;
				end
				PH_THIRD: window_copy(b + 18, size, f);
				default: begin
					if (bits_left == 0) begin
						flag_word = b;
						hdr_cnt = 1;
						phase = PH_FLAGWORD;
					end else if (flag_word & 32'h80000000) begin
						window_put(b);
						token_done();
					end else begin
						held1 = b;
						phase = PH_SECOND;
					end
				end
			endcase
		endfunction

		function void rle_byte(int unsigned b, int unsigned size);
			int unsigned cnt;
			if (phase == PH_RLE_LIT) begin
				emit(b);
				if (rle_left != 0) rle_left--;
				if (rle_left == 0) phase = PH_START;
			end else if (phase == PH_RLE_FILL) begin
				for (int unsigned k = 0; k < rle_left; k++) emit(b);
				rle_left = 0;
				phase = PH_START;
			end else begin
				cnt = b & 127;
				if (cnt == 0 || cnt > size - dec_cnt) begin
					err = lzsr_pkg::ST_BAD_RUN;
					return;
				end
				rle_left = cnt;
				phase = (b & 128) ? PH_RLE_LIT : PH_RLE_FILL;
			end
		endfunction

		function void note_input(lzsr_pkg::in_word_t w);
			int unsigned b, f, size;
			bit done;
			b = w.data_byte;
			done = 0;
			step_n = 0;
			lane = 0;
			lane_n = 0;
			if (phase == PH_IDLE) start_stream();
			f = fmt_eff();
			size = size_reg & lzsr_pkg::SIZE_MASK;
			if (phase == PH_START && dec_cnt >= size) begin
				// Nothing left to decode: the byte is dropped.
				done = 1;
			end else begin
				cons_cnt = (cons_cnt + 1) & 32'h1FFFFFF;
				if (f == FMT_LZSS) lzss_byte(b, size);
				else if (f >= FMT_SLIDE && f <= FMT_STRICT4) slide_byte(b, size, f);
				else if (f == FMT_RLE) rle_byte(b, size);
				else emit(b);
				if (err != lzsr_pkg::ST_OK) done = 1;
				else if (phase == PH_START && dec_cnt >= size) done = 1;
				else if (w.end_of_input) begin
					err = lzsr_pkg::ST_TRUNC;
					done = 1;
				end
			end
			if (done || lane_n > 0) put_word(1, done);
			else if (step_n > 0) pending_words[pending_words.size()-1].last_of_run = 1;
			if (done) phase = PH_IDLE;
		endfunction

		function void check_word(lzsr_pkg::out_word_t got);
			lzsr_pkg::out_word_t exp_w;
			words_seen++;
			if (pending_words.size() == 0) begin
				$error("unexpected decoded word %h", got);
				errors++;
				return;
			end
			exp_w = pending_words.pop_front();
			if (got.out_bytes !== exp_w.out_bytes) begin
				$error("out_bytes: expected %h, got %h", exp_w.out_bytes, got.out_bytes);
				errors++;
			end
			if (got.byte_count !== exp_w.byte_count) begin
				$error("byte_count: expected %0d, got %0d", exp_w.byte_count, got.byte_count);
				errors++;
			end
			if (got.last_of_run !== exp_w.last_of_run) begin
				$error("last_of_run: expected %0d, got %0d", exp_w.last_of_run,
					got.last_of_run);
				errors++;
			end
			if (got.stream_done !== exp_w.stream_done) begin
				$error("stream_done: expected %0d, got %0d", exp_w.stream_done,
					got.stream_done);
				errors++;
			end
			if (got.status !== exp_w.status) begin
				$error("status: expected %0d, got %0d", exp_w.status, got.status);
				errors++;
			end
			if (got.bytes_consumed !== exp_w.bytes_consumed) begin
				$error("bytes_consumed: expected %0d, got %0d", exp_w.bytes_consumed,
					got.bytes_consumed);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          comp_valid;
	logic                          comp_stall;
	lzsr_pkg::in_word_t            comp_word;
	logic                          dec_valid;
	logic                          dec_stall;
	lzsr_pkg::out_word_t           dec_word;
	logic                          psel, penable, pwrite;
	logic [lzsr_pkg::ADDR_W-1:0]   paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;

	decomp_scoreboard    sb;
	lzsr_pkg::in_word_t  stim[$];
	bit                  quiet;       // no random gaps or stalls on either side while set
	bit                  hold_go;     // asks the receiver for one long hold-off
	int                  hold_left;
	int                  stall_left;
	int                  bytes_sent;
	int                  phases_run;

	lz_slide_rle_decompressor dut (
		.clk(clk), .arst_n(arst_n),
		.comp_valid(comp_valid), .comp_stall(comp_stall), .comp_word(comp_word),
		.dec_valid(dec_valid), .dec_stall(dec_stall), .dec_word(dec_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Receiver: takes decoded words, stalls a random number of cycles after
	// each one, and on request holds off long enough for the block to fill up
	// and push back on its compressed input.
	always @(posedge clk) begin
		if (arst_n && dec_valid && !dec_stall) begin
			sb.check_word(dec_word);
			stall_left = quiet ? 0 : $urandom_range(0, 16);
		end
		if (hold_go) begin
			hold_go = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			dec_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			dec_stall <= 1'b1;
		end else begin
			dec_stall <= 1'b0;
		end
	end

	// Offers one compressed word after a random gap and waits for it to be
	// taken. Valid stays high across back-to-back words.
	task automatic send_word(lzsr_pkg::in_word_t w);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			comp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		comp_valid <= 1'b1;
		comp_word <= w;
		forever begin
			@(posedge clk);
			if (!comp_stall) break;
		end
		sb.note_input(w);
		bytes_sent++;
	endtask

	// Setup cycle, access cycle, then psel drops and the bus idles before the next transfer.
	task automatic apb_write(logic [lzsr_pkg::ADDR_W-1:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.configure((addr == ADDR_FORMAT) ? lzsr_pkg::REG_FORMAT : lzsr_pkg::REG_SIZE,
			data);
		@(posedge clk);
	endtask

	// Waits until every predicted word has come out, then lets the block
	// finish any byte that causes no word.
	task automatic wait_drained();
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(int fmt, int unsigned size);
		wait_drained();
		apb_write(ADDR_FORMAT, fmt);
		apb_write(ADDR_SIZE, size);
		while (stim.size() != 0) send_word(stim.pop_front());
		comp_valid <= 1'b0;
		phases_run++;
	endtask

	function automatic void put_byte(int b);
		lzsr_pkg::in_word_t w;
		w.data_byte = b[7:0];
		w.end_of_input = 1'b0;
		stim.push_back(w);
	endfunction

	function automatic void mark_end();
		stim[stim.size()-1].end_of_input = 1'b1;
	endfunction

	function automatic int min_of(int a, int b);
		return (a < b) ? a : b;
	endfunction

	function automatic void gen_lzss(int size);
		int d, flags, cnt, pos;
		d = 0;
		while (d < size) begin
			flags = $urandom_range(0, 255);
			put_byte(flags);
			for (int bit_i = 0; bit_i < 8 && d < size; bit_i++) begin
				if (flags[bit_i]) begin
					put_byte($urandom);
					d++;
				end else begin
					cnt = $urandom_range(3, 20);
					if (cnt > size - d && size - d >= 3 && $urandom_range(0, 9) != 0)
						cnt = size - d;
					pos = $urandom_range(0, 1023);
					put_byte(pos[7:0]);
					put_byte({pos[9:8], 6'(cnt - 3)});
					d += cnt;
				end
			end
		end
	endfunction

	function automatic void gen_slide(int size);
		int d, rem, cnt, back_dist, nib, ext;
		logic [31:0] flags;
		logic [11:0] dm1;
		bit first;
		d = 0;
		first = 1;
		repeat (4) put_byte($urandom);
		while (d < size) begin
			flags = $urandom;
			// The first token is a literal so that back-references have data.
			if (first) flags[31] = 1'b1;
			first = 0;
			for (int k = 3; k >= 0; k--) put_byte(flags[8*k +: 8]);
			for (int bit_i = 31; bit_i >= 0 && d < size; bit_i--) begin
				if (flags[bit_i]) begin
					put_byte($urandom);
					d++;
				end else begin
					rem = size - d;
					if ($urandom_range(0, 4) == 0) begin
						nib = 0;
						ext = $urandom_range(0, 30);
						cnt = 18 + ext;
					end else begin
						nib = $urandom_range(1, 15);
						cnt = nib + 2;
					end
					if (cnt > rem && rem >= 3 && $urandom_range(0, 9) != 0) begin
						if (rem <= 17) begin
							nib = rem - 2;
						end else begin
							nib = 0;
							ext = rem - 18;
						end
						cnt = rem;
					end
					if ($urandom_range(0, 9) == 0) back_dist = $urandom_range(1, 4096);
					else back_dist = $urandom_range(1, min_of(d, 4096));
					dm1 = 12'(back_dist - 1);
					put_byte({4'(nib), dm1[11:8]});
					put_byte(dm1[7:0]);
					if (nib == 0) put_byte(ext);
					d += cnt;
				end
			end
		end
	endfunction

	function automatic void gen_rle(int size);
		int d, run;
		d = 0;
		while (d < size) begin
			run = $urandom_range(1, 127);
			if ($urandom_range(0, 14) != 0) run = $urandom_range(1, min_of(127, size - d));
			if ($urandom_range(0, 1)) begin
				put_byte(128 | run);
				repeat (run) put_byte($urandom);
			end else begin
				put_byte(run);
				put_byte($urandom);
			end
			d += run;
		end
	endfunction

	// One random stream: well formed most of the time, sometimes cut short,
	// sometimes plain noise.
	function automatic void gen_stream(int fmt, int size);
		int first_idx, cut;
		first_idx = stim.size();
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 8)) put_byte($urandom);
			foreach (stim[i]) if (i >= first_idx) stim[i].end_of_input = $urandom_range(0, 1);
			return;
		end
		case (fmt)
			FMT_LZSS: gen_lzss(size);
			FMT_SLIDE, FMT_STRICT3, FMT_STRICT4: gen_slide(size);
			FMT_RLE: gen_rle(size);
			default: repeat ((size == 0) ? 1 : size) put_byte($urandom);
		endcase
		if (stim.size() == first_idx) put_byte($urandom);
		if ($urandom_range(0, 9) == 0 && stim.size() > first_idx + 1) begin
			cut = $urandom_range(first_idx + 1, stim.size() - 1);
			while (stim.size() > cut) void'(stim.pop_back());
			mark_end();
		end else if ($urandom_range(0, 1)) begin
			mark_end();
		end
	endfunction

	initial begin
		int fmt;
		int unsigned size;
		clk = 1'b0;
		arst_n = 1'b0;
		comp_valid = 1'b0;
		comp_word = '0;
		dec_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 0;
		hold_go = 0;
		hold_left = 0;
		stall_left = 0;
		bytes_sent = 0;
		phases_run = 0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Raw copy with a size of zero: each byte is dropped and ends a stream.
		put_byte(8'hFF); mark_end();
		put_byte(8'h00);
		run_phase(FMT_RAW, 0);

		// Raw copy of the extreme byte values.
		put_byte(8'h00); put_byte(8'hFF); put_byte(8'h5A);
		run_phase(FMT_RAW, 3);

		// An unused format code decodes as raw copy.
		put_byte(8'hAA); put_byte(8'h55);
		run_phase(FMT_SPARE7, 2);

		// LZSS at the largest size: a literal, a longest reference from the
		// top of the ring, then an early end of input.
		put_byte(8'h01); put_byte(8'h11); put_byte(8'hFF); put_byte(8'hFF);
		mark_end();
		run_phase(FMT_LZSS, 24'hFFFFFF);

		// Lenient slide: the farthest, longest reference reads zeros before
		// the stream start, then the input ends early.
		repeat (4) put_byte(8'h00);
		repeat (4) put_byte(8'h00);
		put_byte(8'h0F); put_byte(8'hFF); put_byte(8'hFF);
		mark_end();
		run_phase(FMT_SLIDE, 300);

		// Strict slide: a reference before the stream start is a bad distance,
		// and a reference past the size is an overrun in the next stream.
		repeat (4) put_byte(8'hC3);
		put_byte(8'h00); put_byte(8'h00); put_byte(8'h00); put_byte(8'h00);
		put_byte(8'h30); put_byte(8'h00);
		repeat (4) put_byte(8'hC3);
		put_byte(8'h80); put_byte(8'h00); put_byte(8'h00); put_byte(8'h00);
		put_byte(8'h11);
		put_byte(8'hF0); put_byte(8'h00);
		run_phase(FMT_STRICT3, 10);

		// Run-length: zero run, run past the size, then a well-formed stream.
		put_byte(8'h00);
		put_byte(8'h06);
		put_byte(8'h83); put_byte(8'h01); put_byte(8'h02); put_byte(8'h03);
		put_byte(8'h02); put_byte(8'h77);
		run_phase(FMT_RLE, 5);

		// Random phases: a new setting each time, one to three streams each.
		while (bytes_sent < 245) begin
			fmt = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
			case ($urandom_range(0, 11))
				0: size = 0;
				1: size = $urandom_range(100, 400);
				default: size = $urandom_range(1, 40);
			endcase
			quiet = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) gen_stream(fmt, size);
			// Keep the whole run near its intended length.
			while (stim.size() > 1 && bytes_sent + stim.size() > 265) void'(stim.pop_back());
			if (phases_run == 7) hold_go = 1;
			run_phase(fmt, size);
		end
		quiet = 0;

		wait_drained();
		$display("Sent %0d compressed bytes in %0d settings, checked %0d decoded words.",
			bytes_sent, phases_run, sb.words_seen);
		if (sb.errors == 0) begin
			$display("[lz_slide_rle_decompressor] OK");
		end else begin
			$display("[lz_slide_rle_decompressor] ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20ms;
		$display("[lz_slide_rle_decompressor] ERROR");
		$finish;
	end

endmodule

[lz_slide_rle_decompressor.f]
design/lzsr_pkg.sv
design/lzsr_ram.sv
design/lzsr_datapath.sv
design/lzsr_ctrl.sv
design/lz_slide_rle_decompressor.sv
bench/tb.sv
